FILE: hw/rtl/hss_pkg.sv
`default_nettype none

package hss_pkg;

    // Geometry
    localparam int SPEAKERS = 4;
    localparam int SLOTS    = 2 * SPEAKERS;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int TIME_W   = 48;
    localparam int PROB_W   = 16;
    localparam int LABEL_W  = 3;
    localparam int PAD_W    = 24;
    localparam int FRAME_W  = 20;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 24;

    // Register map
    typedef enum logic [CIDX_W-1:0] {
        REG_ONSET      = 3'd0,
        REG_OFFSET     = 3'd1,
        REG_FRAME      = 3'd2,
        REG_PAD_BEFORE = 3'd3,
        REG_PAD_AFTER  = 3'd4,
        REG_MIN_GAP    = 3'd5,
        REG_MIN_LENGTH = 3'd6
    } hss_reg_t;

    localparam logic [PROB_W-1:0]  ONSET_RST  = 16'd16384;
    localparam logic [PROB_W-1:0]  OFFSET_RST = 16'd16384;
    localparam logic [FRAME_W-1:0] FRAME_RST  = 20'd80000;

    typedef struct packed {
        logic [PROB_W-1:0]  onset;
        logic [PROB_W-1:0]  offset;
        logic [FRAME_W-1:0] frame_us;
        logic [PAD_W-1:0]   pad_before;
        logic [PAD_W-1:0]   pad_after;
        logic [PAD_W-1:0]   min_gap;
        logic [PAD_W-1:0]   min_length;
    } hss_cfg_t;

    // Raw segment found by a lane
    typedef struct packed {
        logic              vld;
        logic [TIME_W-1:0] b;
        logic [TIME_W-1:0] e;
    } hss_cand_t;

    // Pipeline advance strobes
    typedef struct packed {
        logic a;
        logic b;
        logic c;
    } hss_adv_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hss_lane.sv
`default_nettype none

module hss_lane
    import hss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [PROB_W-1:0] prob,
    input  logic              fin,
    input  logic [TIME_W-1:0] t,
    input  logic [TIME_W-1:0] total,
    input  hss_cfg_t          cfg,
    output hss_cand_t         held_cand,
    output hss_cand_t         open_cand
);

    logic              active_reg, active_next;
    logic              held_reg, held_next;
    logic [TIME_W-1:0] begin_reg, begin_next;
    logic [TIME_W-1:0] end_reg, end_next;
    hss_cand_t         held_cand_reg, held_cand_next;
    hss_cand_t         open_cand_reg, open_cand_next;

    logic              now;
    logic              opening;
    logic              closing;
    logic              gap_ok;
    logic              emit_prev;
    logic [TIME_W-1:0] gap;

    // Hysteresis, gap merge and flush for one speaker
    always_comb
    begin
        now       = active_reg ? (prob >= cfg.offset) : (prob >= cfg.onset);
        opening   = now & ~active_reg;
        closing   = ~now & active_reg;
        gap       = t - end_reg;
        gap_ok    = (gap <= TIME_W'(cfg.min_gap));
        emit_prev = opening & held_reg & ~gap_ok;

        held_next  = opening ? 1'b0 : (closing ? 1'b1 : held_reg);
        begin_next = (opening & ~(held_reg & gap_ok)) ? t : begin_reg;
        end_next   = closing ? t : end_reg;

        held_cand_next.vld = emit_prev | (fin & ~now & held_next);
        held_cand_next.b   = begin_reg;
        held_cand_next.e   = end_next;

        open_cand_next.vld = fin & now;
        open_cand_next.b   = begin_next;
        open_cand_next.e   = total;

        active_next = now;
    end

    // Hold lane state; clear after the last frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            held_reg   <= 1'b0;
            begin_reg  <= '0;
            end_reg    <= '0;
        end
        else if (accept)
        begin
            if (fin)
            begin
                active_reg <= 1'b0;
                held_reg   <= 1'b0;
                begin_reg  <= '0;
                end_reg    <= '0;
            end
            else
            begin
                active_reg <= active_next;
                held_reg   <= held_next;
                begin_reg  <= begin_next;
                end_reg    <= end_next;
            end
        end
    end

    // Capture candidates for the padding stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_cand_reg <= held_cand_next;
            open_cand_reg <= open_cand_next;
        end
    end

    assign held_cand = held_cand_reg;
    assign open_cand = open_cand_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/hss_trim.sv
`default_nettype none

module hss_trim
    import hss_pkg::*;
(
    input  logic              clk,
    input  hss_adv_t          adv,
    input  hss_cand_t         cand,
    input  hss_cfg_t          cfg,
    output logic              keep,
    output logic [TIME_W-1:0] st,
    output logic [TIME_W-1:0] en
);

    logic              vld_b_reg;
    logic [TIME_W-1:0] st_b_reg, st_b_next;
    logic [TIME_W-1:0] en_b_reg, en_b_next;
    logic [TIME_W-1:0] st_c_reg;
    logic [TIME_W-1:0] en_c_reg;
    logic [TIME_W:0]   en_sum;
    logic [TIME_W-1:0] pad_b;
    logic [TIME_W-1:0] len;

    // Pad start (floored at zero) and end (saturated)
    always_comb
    begin
        pad_b     = TIME_W'(cfg.pad_before);
        st_b_next = (cand.b > pad_b) ? (cand.b - pad_b) : '0;
        en_sum    = {1'b0, cand.e} + (TIME_W + 1)'(cfg.pad_after);
        en_b_next = en_sum[TIME_W] ? {TIME_W{1'b1}} : en_sum[TIME_W-1:0];
    end

    // Drop segments below the minimum length
    always_comb
    begin
        len = en_b_reg - st_b_reg;
        if (en_b_reg >= st_b_reg)
        begin
            keep = vld_b_reg & (len >= TIME_W'(cfg.min_length));
        end
        else
        begin
            keep = vld_b_reg & (cfg.min_length == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.b)
        begin
            vld_b_reg <= cand.vld;
            st_b_reg  <= st_b_next;
            en_b_reg  <= en_b_next;
        end
        if (adv.c)
        begin
            st_c_reg <= st_b_reg;
            en_c_reg <= en_b_reg;
        end
    end

    assign st = st_c_reg;
    assign en = en_c_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/hss_merge.sv
`default_nettype none

module hss_merge
    import hss_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [SLOTS-1:0]             keep,
    input  logic [SLOTS-1:0][TIME_W-1:0] st,
    input  logic [SLOTS-1:0][TIME_W-1:0] en,
    output logic                         ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [LABEL_W-1:0]           speaker_label,
    output logic [TIME_W-1:0]            start_us,
    output logic [TIME_W-1:0]            end_us,
    output logic                         last_of_item
);

    logic [SLOTS-1:0]  mask_reg;
    logic [SLOTS-1:0]  sel;
    logic [SLOT_W-1:0] idx;
    logic [SLOT_W-1:0] spk;
    logic              last;

    // Pick the lowest pending slot: speaker order, held before flushed
    always_comb
    begin
        sel = mask_reg & (~mask_reg + SLOTS'(1));
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                idx = SLOT_W'(i);
            end
        end
        spk  = idx >> 1;
        last = ((mask_reg & ~sel) == '0);
    end

    assign out_valid     = |mask_reg;
    assign ready         = ~out_valid | (out_ready & last);
    assign speaker_label = LABEL_W'(spk) + LABEL_W'(1);
    assign start_us      = st[idx];
    assign end_us        = en[idx];
    assign last_of_item  = last;

    // Load a new word set, or retire the delivered word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (load)
        begin
            mask_reg <= keep;
        end
        else if (out_valid & out_ready)
        begin
            mask_reg <= mask_reg & ~sel;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hysteresis_speaker_segmenter.sv
`default_nettype none

// Channel  | Handshake              | Words
// ---------+------------------------+-------------------------------------------
// in       | in_valid / in_ready    | prob_0..prob_3, final_frame
// out      | out_valid / out_ready  | speaker_label, start_us, end_us, last_of_item
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A frame moves through three registered stages (lane update, padding,
// length filter) and its kept segments leave one word per cycle while
// out_ready is high, 0 to 8 words per frame. The first word is valid once
// the frame has passed the lane, padding and length-filter registers.
// Reset clears all speaker state, the frame clock and the pipeline; registers
// return to their defaults. A stalled output holds the pipeline behind it.

module hysteresis_speaker_segmenter
    import hss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PROB_W-1:0]    prob_0,
    input  logic [PROB_W-1:0]    prob_1,
    input  logic [PROB_W-1:0]    prob_2,
    input  logic [PROB_W-1:0]    prob_3,
    input  logic                 final_frame,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [LABEL_W-1:0]   speaker_label,
    output logic [TIME_W-1:0]    start_us,
    output logic [TIME_W-1:0]    end_us,
    output logic                 last_of_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CIDX_W-1:0]    cfg_index,
    input  logic [CDATA_W-1:0]   cfg_data
);

    hss_cfg_t          cfg_reg;
    logic [TIME_W-1:0] frame_time_reg;
    logic [TIME_W-1:0] total;
    logic              a_valid_reg;
    logic              b_valid_reg;
    logic              ser_ready;
    hss_adv_t          adv;

    logic [SPEAKERS-1:0][PROB_W-1:0] prob;
    hss_cand_t [SLOTS-1:0]           cand;
    logic [SLOTS-1:0]                keep;
    logic [SLOTS-1:0][TIME_W-1:0]    st;
    logic [SLOTS-1:0][TIME_W-1:0]    en;

    assign prob = {prob_3, prob_2, prob_1, prob_0};

    // Pipeline flow control
    assign adv.c    = b_valid_reg & ser_ready;
    assign adv.b    = a_valid_reg & (~b_valid_reg | adv.c);
    assign in_ready = ~a_valid_reg | adv.b;
    assign adv.a    = in_valid & in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (~b_valid_reg | adv.c)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Advance the frame clock; restart it after the last frame
    assign total = frame_time_reg + TIME_W'(cfg_reg.frame_us);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_time_reg <= '0;
        end
        else if (adv.a)
        begin
            frame_time_reg <= final_frame ? '0 : total;
        end
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.onset      <= ONSET_RST;
            cfg_reg.offset     <= OFFSET_RST;
            cfg_reg.frame_us   <= FRAME_RST;
            cfg_reg.pad_before <= '0;
            cfg_reg.pad_after  <= '0;
            cfg_reg.min_gap    <= '0;
            cfg_reg.min_length <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (hss_reg_t'(cfg_index))
                REG_ONSET:      cfg_reg.onset      <= cfg_data[PROB_W-1:0];
                REG_OFFSET:     cfg_reg.offset     <= cfg_data[PROB_W-1:0];
                REG_FRAME:      cfg_reg.frame_us   <= cfg_data[FRAME_W-1:0];
                REG_PAD_BEFORE: cfg_reg.pad_before <= cfg_data[PAD_W-1:0];
                REG_PAD_AFTER:  cfg_reg.pad_after  <= cfg_data[PAD_W-1:0];
                REG_MIN_GAP:    cfg_reg.min_gap    <= cfg_data[PAD_W-1:0];
                REG_MIN_LENGTH: cfg_reg.min_length <= cfg_data[PAD_W-1:0];
                default:        ;
            endcase
        end
    end

    // One lane per speaker, two trim slots per lane
    for (genvar s = 0; s < SPEAKERS; s++)
    begin : g_lane
        hss_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .accept    (adv.a),
            .prob      (prob[s]),
            .fin       (final_frame),
            .t         (frame_time_reg),
            .total     (total),
            .cfg       (cfg_reg),
            .held_cand (cand[2*s]),
            .open_cand (cand[2*s+1])
        );
    end

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_trim
        hss_trim u_trim (
            .clk  (clk),
            .adv  (adv),
            .cand (cand[k]),
            .cfg  (cfg_reg),
            .keep (keep[k]),
            .st   (st[k]),
            .en   (en[k])
        );
    end

    // Merge the lanes into one ordered word stream
    hss_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (adv.c),
        .keep          (keep),
        .st            (st),
        .en            (en),
        .ready         (ser_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .speaker_label (speaker_label),
        .start_us      (start_us),
        .end_us        (end_us),
        .last_of_item  (last_of_item)
    );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import hss_pkg::*;

    localparam logic [CIDX_W-1:0] REG_NONE = 3'd7;
    localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [SPEAKERS-1:0][PROB_W-1:0] prob;
        logic                            fin;
    } frame_t;

    typedef struct packed {
        logic [LABEL_W-1:0] spk;
        logic [TIME_W-1:0]  t_start;
        logic [TIME_W-1:0]  t_end;
        logic               last;
    } seg_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [PROB_W-1:0]    prob_0 = '0;
    logic [PROB_W-1:0]    prob_1 = '0;
    logic [PROB_W-1:0]    prob_2 = '0;
    logic [PROB_W-1:0]    prob_3 = '0;
    logic                 final_frame = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [LABEL_W-1:0]   speaker_label;
    logic [TIME_W-1:0]    start_us;
    logic [TIME_W-1:0]    end_us;
    logic                 last_of_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CIDX_W-1:0]    cfg_index = '0;
    logic [CDATA_W-1:0]   cfg_data = '0;

    hysteresis_speaker_segmenter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .prob_0        (prob_0),
        .prob_1        (prob_1),
        .prob_2        (prob_2),
        .prob_3        (prob_3),
        .final_frame   (final_frame),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .speaker_label (speaker_label),
        .start_us      (start_us),
        .end_us        (end_us),
        .last_of_item  (last_of_item),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Register copies used by the segment predictor
    logic [PROB_W-1:0]  thr_on    = ONSET_RST;
    logic [PROB_W-1:0]  thr_off   = OFFSET_RST;
    logic [FRAME_W-1:0] frame_len = FRAME_RST;
    logic [PAD_W-1:0]   pad_pre   = '0;
    logic [PAD_W-1:0]   pad_post  = '0;
    logic [PAD_W-1:0]   gap_max   = '0;
    logic [PAD_W-1:0]   min_len   = '0;

    // Speaker tracking state of the predictor
    logic [TIME_W-1:0] clock_us = '0;
    bit                spk_on    [SPEAKERS];
    bit                held      [SPEAKERS];
    logic [TIME_W-1:0] run_start [SPEAKERS];
    logic [TIME_W-1:0] run_stop  [SPEAKERS];

    frame_t frame_q[$];
    seg_t   expected_segs[$];
    frame_t cur_frame;
    int     frames_queued = 0;
    int     frames_taken = 0;
    int     errors = 0;
    int     send_idle_pct = 23;
    int     recv_idle_pct = 46;
    int     idle_cycles = 0;
    bit     gen_hi [SPEAKERS];

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Pad a raw segment; report whether it survives the length filter
    function automatic bit pad_segment(input int s, input logic [TIME_W-1:0] b,
                                       input logic [TIME_W-1:0] e, output seg_t seg);
        logic [63:0] st;
        logic [63:0] en;
        logic [63:0] len;
        st = (b > pad_pre) ? 64'(b) - 64'(pad_pre) : 64'd0;
        en = 64'(e) + 64'(pad_post);
        if (en > TIME_MAX)
            en = TIME_MAX;
        len = (en >= st) ? en - st : 64'd0;
        seg.spk = LABEL_W'(s + 1);
        seg.t_start = st[TIME_W-1:0];
        seg.t_end = en[TIME_W-1:0];
        seg.last = 1'b0;
        return len >= 64'(min_len);
    endfunction

    // Advance the hysteresis state by one frame and queue the segments it closes or flushes
    function automatic void segment_frame(input frame_t f);
        seg_t              found [2*SPEAKERS];
        seg_t              seg;
        int                n;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] t_next;
        logic [TIME_W-1:0] gap;
        bit                was;
        bit                now;
        n = 0;
        t = clock_us;
        t_next = clock_us + TIME_W'(frame_len);
        for (int s = 0; s < SPEAKERS; s++)
        begin
            was = spk_on[s];
            now = was;
            if (!was && f.prob[s] >= thr_on)
                now = 1'b1;
            else if (was && f.prob[s] < thr_off)
                now = 1'b0;

            if (now && !was)
            begin
                // merge into the held segment if close enough, else emit it
                gap = t - run_stop[s];
                if (held[s] && gap <= TIME_W'(gap_max))
                    held[s] = 1'b0;
                else
                begin
                    if (held[s] && pad_segment(s, run_start[s], run_stop[s], seg))
                    begin
                        found[n] = seg;
                        n++;
                    end
                    held[s] = 1'b0;
                    run_start[s] = t;
                end
            end
            else if (!now && was)
            begin
                run_stop[s] = t;
                held[s] = 1'b1;
            end
            spk_on[s] = now;

            // flush on the last frame of the stream
            if (f.fin)
            begin
                if (now && pad_segment(s, run_start[s], t_next, seg))
                begin
                    found[n] = seg;
                    n++;
                end
                else if (!now && held[s] && pad_segment(s, run_start[s], run_stop[s], seg))
                begin
                    found[n] = seg;
                    n++;
                end
            end
        end

        if (f.fin)
        begin
            clock_us = '0;
            for (int s = 0; s < SPEAKERS; s++)
            begin
                spk_on[s] = 1'b0;
                held[s] = 1'b0;
                run_start[s] = '0;
                run_stop[s] = '0;
            end
        end
        else
            clock_us = t_next;

        if (n > 0)
            found[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_segs.insert(expected_segs.size(), found[i]);
    endfunction

    // Driver: present frames from the queue, with random gaps
    always @(posedge clk)
    begin
        bit busy;
        frame_t nxt;
        if (rst_n)
        begin
            busy = in_valid;
            if (in_valid && in_ready)
            begin
                segment_frame(cur_frame);
                frames_taken++;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (frame_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = frame_q.pop_front();
                    cur_frame = nxt;
                    prob_0 <= nxt.prob[0];
                    prob_1 <= nxt.prob[1];
                    prob_2 <= nxt.prob[2];
                    prob_3 <= nxt.prob[3];
                    final_frame <= nxt.fin;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each segment word against the oldest expected one
    always @(posedge clk)
    begin
        seg_t got;
        seg_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.spk = speaker_label;
                got.t_start = start_us;
                got.t_end = end_us;
                got.last = last_of_item;
                if (expected_segs.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected segment: spk %0d [%0d, %0d] last %0d",
                                 got.spk, got.t_start, got.t_end, got.last);
                end
                else
                begin
                    want = expected_segs.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("segment mismatch: expected spk %0d [%0d, %0d] last %0d",
                                     want.spk, want.t_start, want.t_end, want.last);
                            $display("                  got spk %0d [%0d, %0d] last %0d",
                                     got.spk, got.t_start, got.t_end, got.last);
                        end
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: stop if no channel moves a word for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_ONSET:      thr_on = val[PROB_W-1:0];
            REG_OFFSET:     thr_off = val[PROB_W-1:0];
            REG_FRAME:      frame_len = val[FRAME_W-1:0];
            REG_PAD_BEFORE: pad_pre = val;
            REG_PAD_AFTER:  pad_post = val;
            REG_MIN_GAP:    gap_max = val;
            REG_MIN_LENGTH: min_len = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [CDATA_W-1:0] on, input logic [CDATA_W-1:0] off,
                              input logic [CDATA_W-1:0] frm, input logic [CDATA_W-1:0] pre,
                              input logic [CDATA_W-1:0] post, input logic [CDATA_W-1:0] gap,
                              input logic [CDATA_W-1:0] len);
        write_reg(REG_ONSET, on);
        write_reg(REG_OFFSET, off);
        write_reg(REG_FRAME, frm);
        write_reg(REG_PAD_BEFORE, pre);
        write_reg(REG_PAD_AFTER, post);
        write_reg(REG_MIN_GAP, gap);
        write_reg(REG_MIN_LENGTH, len);
    endtask

    // Hold off until every frame is taken and every segment has come out
    task automatic wait_drained();
        while (frames_taken != frames_queued)
            @(posedge clk);
        while (expected_segs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_frame(input logic [PROB_W-1:0] p0, input logic [PROB_W-1:0] p1,
                              input logic [PROB_W-1:0] p2, input logic [PROB_W-1:0] p3,
                              input bit fin);
        frame_t f;
        f.prob[0] = p0;
        f.prob[1] = p1;
        f.prob[2] = p2;
        f.prob[3] = p3;
        f.fin = fin;
        frame_q.insert(frame_q.size(), f);
        frames_queued++;
    endtask

    // Pick a probability, mostly on the requested side of the current thresholds
    function automatic logic [PROB_W-1:0] pick_prob(input bit hi);
        int top;
        int bot;
        int r;
        top = (thr_on > thr_off) ? int'(thr_on) : int'(thr_off);
        bot = (thr_on < thr_off) ? int'(thr_on) : int'(thr_off);
        r = $urandom_range(0, 99);
        if (r < 8)
            return PROB_W'($urandom_range(0, 65535));
        if (r < 18)
            return PROB_W'($urandom_range(bot, top));
        if (hi)
            return PROB_W'((top > 32768) ? $urandom_range(top, 65535)
                                         : $urandom_range(top, 32768));
        return (bot == 0) ? '0 : PROB_W'($urandom_range(0, bot - 1));
    endfunction

    // Queue one stream of frames with per-speaker activity runs
    task automatic queue_stream(input int len, input bit closed);
        logic [PROB_W-1:0] v [SPEAKERS];
        for (int i = 0; i < len; i++)
        begin
            for (int s = 0; s < SPEAKERS; s++)
            begin
                if ($urandom_range(0, 99) < 30)
                    gen_hi[s] = !gen_hi[s];
                v[s] = pick_prob(gen_hi[s]);
            end
            push_frame(v[0], v[1], v[2], v[3], closed && (i == len - 1));
        end
    endtask

    initial
    begin
        int phase_frames;
        int len;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset thresholds
        push_frame(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        push_frame(16'd32768, 16'd32768, 16'd32768, 16'd32768, 1'b0);
        push_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        push_frame(16'd16383, 16'd16383, 16'd16383, 16'd16383, 1'b0);
        push_frame(16'd16384, 16'd16384, 16'd16384, 16'd16384, 1'b0);
        push_frame(16'd0, 16'd32768, 16'd16383, 16'd16384, 1'b1);
        push_frame(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        push_frame(16'd32768, 16'd32768, 16'd32768, 16'd32768, 1'b1);
        // held segment plus reopened run on the final frame: two words per speaker
        push_frame(16'd32768, 16'd32768, 16'd32768, 16'd32768, 1'b0);
        push_frame(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        push_frame(16'd32768, 16'd32768, 16'd32768, 16'd32768, 1'b1);
        push_frame(16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 1'b0);
        push_frame(16'hAAAA, 16'h5555, 16'h8001, 16'h0001, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            // swap idle rates from phase 2, none from phase 4 on
            if (ph == 2)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 23;
            end
            else if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (ph)
                0: set_config(24'd20000, 24'd12000, 24'd1, 24'hFFFFFF, 24'd0, 24'd0, 24'd0);
                1: set_config(24'd32768, 24'd0, 24'd1000000, 24'd50000, 24'hFFFFFF,
                              24'hFFFFFF, 24'd2000000);
                2: set_config(24'd0, 24'd32768, 24'd0, 24'd0, 24'd0, 24'd0, 24'd1);
                3:
                begin
                    set_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd1000, 24'd0,
                               24'd0);
                    write_reg(REG_NONE, 24'hFFFFFF);
                    write_reg(REG_ONSET, 24'd40000);
                    write_reg(REG_OFFSET, 24'd8000);
                end
                default: set_config(CDATA_W'($urandom_range(0, 32768)),
                                    CDATA_W'($urandom_range(0, 32768)),
                                    CDATA_W'($urandom_range(1, 200000)),
                                    CDATA_W'($urandom_range(0, 300000)),
                                    CDATA_W'($urandom_range(0, 300000)),
                                    CDATA_W'($urandom_range(0, 400000)),
                                    CDATA_W'($urandom_range(0, 500000)));
            endcase

            phase_frames = 0;
            while (phase_frames < 40)
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20)
                                                  : $urandom_range(1, 8);
                queue_stream(len, $urandom_range(0, 99) < 85);
                phase_frames += len;
                // in phases 1 and 4, let the output drain completely once mid-phase
                if ((ph == 1 || ph == 4) && phase_frames >= 22 && phase_frames - len < 22)
                    wait_drained();
            end
            wait_drained();
        end

        // Flush any stream left open so trailing state is checked too
        push_frame(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        wait_drained();
        repeat (20) @(posedge clk);

        if (errors == 0 && expected_segs.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: hysteresis_speaker_segmenter.f
hw/rtl/hss_pkg.sv
hw/rtl/hss_lane.sv
hw/rtl/hss_trim.sv
hw/rtl/hss_merge.sv
hw/rtl/hysteresis_speaker_segmenter.sv
tb/sv/testbench.sv
